[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the core RTL
// Clocked property checks, one form with a reset guard, one without.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define SDO_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked at every clock edge, reset included
`define SDO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDO_ASSERT(lbl, clk, rst, prop, msg)
`define SDO_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/sdo_pkg.sv]
// ---------------------------------------------------------------------------
// SDO server package
// Object dictionary codes, command specifiers, abort codes and table layout.
// ---------------------------------------------------------------------------
package sdo_pkg;

  localparam int INPUT_CHANNELS_DEF  = 16;
  localparam int OUTPUT_CHANNELS_DEF = 8;

  localparam int IN_ENTRY_W  = 25;
  localparam int OUT_ENTRY_W = 16;

  localparam logic [IN_ENTRY_W-1:0]  IN_ENTRY_RESET  = 25'h0001E00;
  localparam logic [OUT_ENTRY_W-1:0] OUT_ENTRY_RESET = 16'h0000;

  localparam logic [10:0] RX_BASE = 11'h600;
  localparam logic [10:0] TX_BASE = 11'h580;

  localparam logic [7:0] NODE_UNCONFIGURED = 8'hFF;
  localparam logic [3:0] FRAME_DLC         = 4'd8;

  localparam logic [7:0] CMD_UPLOAD  = 8'h40;
  localparam logic [7:0] CMD_DL_FOUR = 8'h23;
  localparam logic [7:0] CMD_DL_TWO  = 8'h2B;
  localparam logic [7:0] CMD_DL_ONE  = 8'h2F;

  localparam logic [7:0] SPEC_UPLOAD = 8'h43;
  localparam logic [7:0] SPEC_ACK    = 8'h60;
  localparam logic [7:0] SPEC_ABORT  = 8'h80;

  localparam logic [15:0] IDX_BOARD   = 16'h2000;
  localparam logic [15:0] IDX_INPUTS  = 16'h2100;
  localparam logic [15:0] IDX_OUTPUTS = 16'h2200;

  localparam logic [31:0] ABORT_NO_OBJECT = 32'h06020000;
  localparam logic [31:0] ABORT_BAD_SUB   = 32'h06090011;
  localparam logic [31:0] ABORT_BAD_CMD   = 32'h05040001;

  localparam int BOARD_WORDS = 5;

  // configuration register indexes
  localparam logic [2:0] REG_NODE_NUMBER  = 3'd0;
  localparam logic [2:0] REG_BOARD_MODEL  = 3'd1;
  localparam logic [2:0] REG_BOARD_FW     = 3'd2;
  localparam logic [2:0] REG_BOARD_CAPS   = 3'd3;
  localparam logic [2:0] REG_BOARD_INPUTS = 3'd4;
  localparam logic [2:0] REG_BOARD_OUTS   = 3'd5;

endpackage

[rtl/core/sdo_expedited_server.sv]
// ---------------------------------------------------------------------------
// Expedited SDO server
// Answers uploads and expedited downloads on the channel tables of one node.
// ---------------------------------------------------------------------------
// Response: the frame is captured on accept, evaluated in the evaluate state
// and registered from there; an answered frame waits in that state while the
// response register is full. A new frame is taken only once the last has left it.
// Reset: node unconfigured (255), board words zero, every table entry
// marked unwritten so it reads as its reset value; no clearing pass.
module sdo_expedited_server #(
  parameter int INPUT_CHANNELS  = sdo_pkg::INPUT_CHANNELS_DEF,
  parameter int OUTPUT_CHANNELS = sdo_pkg::OUTPUT_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] rx_id,
  input  logic [3:0]  rx_length,
  input  logic [7:0]  rx_byte0,
  input  logic [7:0]  rx_byte1,
  input  logic [7:0]  rx_byte2,
  input  logic [7:0]  rx_byte3,
  input  logic [7:0]  rx_byte4,
  input  logic [7:0]  rx_byte5,
  input  logic [7:0]  rx_byte6,
  input  logic [7:0]  rx_byte7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] tx_id,
  output logic [7:0]  tx_byte0,
  output logic [7:0]  tx_byte1,
  output logic [7:0]  tx_byte2,
  output logic [7:0]  tx_byte3,
  output logic [7:0]  tx_byte4,
  output logic [7:0]  tx_byte5,
  output logic [7:0]  tx_byte6,
  output logic [7:0]  tx_byte7
);

`include "assert_macros.svh"

  localparam int IAW = (INPUT_CHANNELS > 1) ? $clog2(INPUT_CHANNELS) : 1;
  localparam int OAW = (OUTPUT_CHANNELS > 1) ? $clog2(OUTPUT_CHANNELS) : 1;
  localparam int IEW = sdo_pkg::IN_ENTRY_W;
  localparam int OEW = sdo_pkg::OUT_ENTRY_W;

  localparam logic [7:0]  IN_COUNT   = 8'(INPUT_CHANNELS);
  localparam logic [7:0]  OUT_COUNT  = 8'(OUTPUT_CHANNELS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic state;

  // configuration registers
  logic [7:0]  node_number;
  logic [31:0] board_word [sdo_pkg::BOARD_WORDS];

  // captured item
  logic [10:0] id_q;
  logic [3:0]  len_q;
  logic [7:0]  cmd_q;
  logic [15:0] idx_q;
  logic [7:0]  sub_q;
  logic [31:0] val_q;

  // channel tables
  logic [IEW-1:0] in_mem  [INPUT_CHANNELS];
  logic [OEW-1:0] out_mem [OUTPUT_CHANNELS];
  logic [INPUT_CHANNELS-1:0]  in_vld;
  logic [OUTPUT_CHANNELS-1:0] out_vld;
  logic [IEW-1:0] in_rd;
  logic [OEW-1:0] out_rd;
  logic           in_rd_vld;
  logic           out_rd_vld;

  logic [7:0] ch_rx;
  logic [7:0] ch_q;
  logic       accept;
  logic       frame_ok;
  logic       go;
  logic       load;
  logic       in_we_raw;
  logic       out_we_raw;
  logic       in_we;
  logic       out_we;
  logic [7:0]  spec;
  logic [31:0] word;
  logic [IEW-1:0] in_word;
  logic [OEW-1:0] out_word;
  logic       in_ch_ok;
  logic       out_ch_ok;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign ch_rx    = rx_byte3 - 8'd1;
  assign ch_q     = sub_q - 8'd1;

  assign in_ch_ok  = (sub_q != 8'd0) && (ch_q < IN_COUNT);
  assign out_ch_ok = (sub_q != 8'd0) && (ch_q < OUT_COUNT);

  assign frame_ok = (node_number != sdo_pkg::NODE_UNCONFIGURED)
                 && (id_q == sdo_pkg::RX_BASE + {3'b000, node_number})
                 && (len_q == sdo_pkg::FRAME_DLC);

  // unwritten entries read as their reset value
  assign in_word  = in_rd_vld  ? in_rd  : sdo_pkg::IN_ENTRY_RESET;
  assign out_word = out_rd_vld ? out_rd : sdo_pkg::OUT_ENTRY_RESET;

  // ignored frames leave without waiting on the output register
  assign go     = (state == ST_EVAL) && (!frame_ok || !out_valid || out_ready);
  assign load   = go && frame_ok;
  assign in_we  = load && in_we_raw;
  assign out_we = load && out_we_raw;

  always_comb begin
    spec       = sdo_pkg::SPEC_ABORT;
    word       = sdo_pkg::ABORT_BAD_CMD;
    in_we_raw  = 1'b0;
    out_we_raw = 1'b0;
    case (cmd_q) inside
      sdo_pkg::CMD_UPLOAD: begin
        spec = sdo_pkg::SPEC_ABORT;
        word = sdo_pkg::ABORT_NO_OBJECT;
        if (idx_q == sdo_pkg::IDX_BOARD) begin
          if (sub_q >= 8'd1 && sub_q <= 8'(sdo_pkg::BOARD_WORDS)) begin
            spec = sdo_pkg::SPEC_UPLOAD;
            word = board_word[ch_q[2:0]];
          end
        end else if (idx_q == sdo_pkg::IDX_INPUTS) begin
          if (sub_q == 8'd0) begin
            spec = sdo_pkg::SPEC_UPLOAD;
            word = {24'd0, IN_COUNT};
          end else if (in_ch_ok) begin
            spec = sdo_pkg::SPEC_UPLOAD;
            word = {{(32-IEW){1'b0}}, in_word};
          end
        end else if (idx_q == sdo_pkg::IDX_OUTPUTS) begin
          if (sub_q == 8'd0) begin
            spec = sdo_pkg::SPEC_UPLOAD;
            word = {24'd0, OUT_COUNT};
          end else if (out_ch_ok) begin
            spec = sdo_pkg::SPEC_UPLOAD;
            word = {{(32-OEW){1'b0}}, out_word};
          end
        end
      end
      sdo_pkg::CMD_DL_FOUR, sdo_pkg::CMD_DL_TWO, sdo_pkg::CMD_DL_ONE: begin
        spec = sdo_pkg::SPEC_ABORT;
        word = sdo_pkg::ABORT_BAD_SUB;
        if (idx_q == sdo_pkg::IDX_INPUTS && in_ch_ok) begin
          spec      = sdo_pkg::SPEC_ACK;
          word      = 32'd0;
          in_we_raw = 1'b1;
        end else if (idx_q == sdo_pkg::IDX_OUTPUTS && out_ch_ok) begin
          spec       = sdo_pkg::SPEC_ACK;
          word       = 32'd0;
          out_we_raw = 1'b1;
        end
      end
      default: begin
        spec = sdo_pkg::SPEC_ABORT;
        word = sdo_pkg::ABORT_BAD_CMD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_number <= sdo_pkg::NODE_UNCONFIGURED;
      for (int i = 0; i < sdo_pkg::BOARD_WORDS; i++) begin
        board_word[i] <= 32'd0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        sdo_pkg::REG_NODE_NUMBER:  node_number   <= cfg_data[7:0];
        sdo_pkg::REG_BOARD_MODEL:  board_word[0] <= cfg_data;
        sdo_pkg::REG_BOARD_FW:     board_word[1] <= cfg_data;
        sdo_pkg::REG_BOARD_CAPS:   board_word[2] <= cfg_data;
        sdo_pkg::REG_BOARD_INPUTS: board_word[3] <= cfg_data;
        sdo_pkg::REG_BOARD_OUTS:   board_word[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (accept) state <= ST_EVAL;
        ST_EVAL: if (go) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_q  <= rx_id;
      len_q <= rx_length;
      cmd_q <= rx_byte0;
      idx_q <= {rx_byte2, rx_byte1};
      sub_q <= rx_byte3;
      val_q <= {rx_byte7, rx_byte6, rx_byte5, rx_byte4};
    end
  end

  // table memories: read on accept, written back in the evaluate cycle
  always_ff @(posedge clk) begin
    if (in_we) begin
      in_mem[ch_q[IAW-1:0]] <= val_q[IEW-1:0];
    end
    if (accept) begin
      in_rd <= in_mem[ch_rx[IAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[ch_q[OAW-1:0]] <= val_q[OEW-1:0];
    end
    if (accept) begin
      out_rd <= out_mem[ch_rx[OAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld     <= '0;
      out_vld    <= '0;
      in_rd_vld  <= 1'b0;
      out_rd_vld <= 1'b0;
    end else begin
      if (in_we) in_vld[ch_q[IAW-1:0]] <= 1'b1;
      if (out_we) out_vld[ch_q[OAW-1:0]] <= 1'b1;
      if (accept) begin
        in_rd_vld  <= in_vld[ch_rx[IAW-1:0]];
        out_rd_vld <= out_vld[ch_rx[OAW-1:0]];
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (load) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_id    <= sdo_pkg::TX_BASE + {3'b000, node_number};
      tx_byte0 <= spec;
      tx_byte1 <= idx_q[7:0];
      tx_byte2 <= idx_q[15:8];
      tx_byte3 <= sub_q;
      tx_byte4 <= word[7:0];
      tx_byte5 <= word[15:8];
      tx_byte6 <= word[23:16];
      tx_byte7 <= word[31:24];
    end
  end

  `SDO_ASSERT(a_no_overwrite, clk, rst, load |-> (!out_valid || out_ready), "response overwritten")
  `SDO_ASSERT(a_one_table_write, clk, rst, $onehot0({in_we, out_we}), "two table writes at once")
  `SDO_ASSERT(a_write_after_read, clk, rst, (in_we || out_we) |-> $past(accept) || $past(state == ST_EVAL), "table write without a read")
  `SDO_ASSERT(a_hold_in_eval, clk, rst, (state == ST_EVAL && !go) |=> (state == ST_EVAL && $stable(sub_q)), "item lost while stalled")
  `SDO_ASSERT_ALWAYS(a_reset_node, clk, (!rst && $past(rst)) |-> node_number == sdo_pkg::NODE_UNCONFIGURED, "node not unconfigured after reset")

endmodule

[verif/tb_sdo_expedited_server.sv]
// ---------------------------------------------------------------------------
// Testbench for the expedited SDO server
// Drives received CAN frames under random idling and back-pressure, predicts
// each response frame from a behavioural copy of the object dictionary and
// compares every response field in order.
// ---------------------------------------------------------------------------
module tb_sdo_expedited_server;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_IN          = sdo_pkg::INPUT_CHANNELS_DEF;
  localparam int N_OUT         = sdo_pkg::OUTPUT_CHANNELS_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [10:0] id;
    logic [3:0]  len;
    logic [63:0] data;  // byte n at [8n+7:8n]
  } can_rx_t;

  typedef struct packed {
    logic [10:0] id;
    logic [63:0] data;
  } can_tx_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [10:0] rx_id = '0;
  logic [3:0]  rx_length = '0;
  logic [7:0]  rx_byte0 = '0, rx_byte1 = '0, rx_byte2 = '0, rx_byte3 = '0;
  logic [7:0]  rx_byte4 = '0, rx_byte5 = '0, rx_byte6 = '0, rx_byte7 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] tx_id;
  logic [7:0]  tx_byte0, tx_byte1, tx_byte2, tx_byte3;
  logic [7:0]  tx_byte4, tx_byte5, tx_byte6, tx_byte7;

  // behavioural copy of the node
  logic [7:0]                      node_id;
  logic [31:0]                     board_word [sdo_pkg::BOARD_WORDS];
  logic [sdo_pkg::IN_ENTRY_W-1:0]  in_chan    [N_IN];
  logic [sdo_pkg::OUT_ENTRY_W-1:0] out_chan   [N_OUT];

  can_tx_t pending_replies [$];
  int      fail_count  = 0;
  int      cycle_count = 0;
  int      hold_cycles = 0;
  bit      idle_enable = 1'b1;

  sdo_expedited_server i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_id     (rx_id),
    .rx_length (rx_length),
    .rx_byte0  (rx_byte0),
    .rx_byte1  (rx_byte1),
    .rx_byte2  (rx_byte2),
    .rx_byte3  (rx_byte3),
    .rx_byte4  (rx_byte4),
    .rx_byte5  (rx_byte5),
    .rx_byte6  (rx_byte6),
    .rx_byte7  (rx_byte7),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tx_id     (tx_id),
    .tx_byte0  (tx_byte0),
    .tx_byte1  (tx_byte1),
    .tx_byte2  (tx_byte2),
    .tx_byte3  (tx_byte3),
    .tx_byte4  (tx_byte4),
    .tx_byte5  (tx_byte5),
    .tx_byte6  (tx_byte6),
    .tx_byte7  (tx_byte7)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Response prediction
  // -------------------------------------------------------------------------
  task automatic predict_reply(input can_rx_t f);
    logic [7:0]  cmd, sub, ch, spec;
    logic [15:0] idx;
    logic [31:0] val, word;
    bit          ok;
    can_tx_t     r;
    cmd  = f.data[7:0];
    idx  = f.data[23:8];
    sub  = f.data[31:24];
    val  = f.data[63:32];
    ch   = sub - 8'd1;
    word = '0;
    ok   = 1'b0;
    if (node_id == sdo_pkg::NODE_UNCONFIGURED || f.id != sdo_pkg::RX_BASE + 11'(node_id) ||
        f.len != sdo_pkg::FRAME_DLC)
      return;
    if (cmd == sdo_pkg::CMD_UPLOAD) begin
      if (idx == sdo_pkg::IDX_BOARD) begin
        if (sub >= 8'd1 && sub <= 8'(sdo_pkg::BOARD_WORDS)) begin
          word = board_word[ch];
          ok   = 1'b1;
        end
      end else if (idx == sdo_pkg::IDX_INPUTS) begin
        if (sub == 8'd0) begin
          word = 32'(N_IN);
          ok   = 1'b1;
        end else if (ch < 8'(N_IN)) begin
          word = 32'(in_chan[ch]);
          ok   = 1'b1;
        end
      end else if (idx == sdo_pkg::IDX_OUTPUTS) begin
        if (sub == 8'd0) begin
          word = 32'(N_OUT);
          ok   = 1'b1;
        end else if (ch < 8'(N_OUT)) begin
          word = 32'(out_chan[ch]);
          ok   = 1'b1;
        end
      end
      spec = ok ? sdo_pkg::SPEC_UPLOAD : sdo_pkg::SPEC_ABORT;
      if (!ok) word = sdo_pkg::ABORT_NO_OBJECT;
    end else if (cmd == sdo_pkg::CMD_DL_FOUR || cmd == sdo_pkg::CMD_DL_TWO ||
                 cmd == sdo_pkg::CMD_DL_ONE) begin
      // size bits of the specifier are not checked
      if (sub != 8'd0 && idx == sdo_pkg::IDX_INPUTS && ch < 8'(N_IN)) begin
        in_chan[ch] = val[sdo_pkg::IN_ENTRY_W-1:0];
        ok = 1'b1;
      end else if (sub != 8'd0 && idx == sdo_pkg::IDX_OUTPUTS && ch < 8'(N_OUT)) begin
        out_chan[ch] = val[sdo_pkg::OUT_ENTRY_W-1:0];
        ok = 1'b1;
      end
      spec = ok ? sdo_pkg::SPEC_ACK : sdo_pkg::SPEC_ABORT;
      word = ok ? 32'd0 : sdo_pkg::ABORT_BAD_SUB;
    end else begin
      spec = sdo_pkg::SPEC_ABORT;
      word = sdo_pkg::ABORT_BAD_CMD;
    end
    r.id   = sdo_pkg::TX_BASE + 11'(node_id);
    r.data = {word, sub, idx, spec};
    pending_replies.push_back(r);
  endtask

  // -------------------------------------------------------------------------
  // Response checking
  // -------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input can_tx_t want, input can_tx_t got);
    if (fail_count < MAX_REPORTS)
      $display("mismatch (%s) at cycle %0d: expected id %h data %h, got id %h data %h",
               what, cycle_count, want.id, want.data, got.id, got.data);
    fail_count++;
  endtask

  always @(posedge clk) begin
    can_tx_t got, want;
    bit      bad;
    int      k;
    if (!rst && out_valid && out_ready) begin
      got.id   = tx_id;
      got.data = {tx_byte7, tx_byte6, tx_byte5, tx_byte4,
                  tx_byte3, tx_byte2, tx_byte1, tx_byte0};
      if (pending_replies.size() == 0) begin
        note_mismatch("no reply expected", '0, got);
      end else begin
        want = pending_replies.pop_front();
        bad  = (want.id != got.id);
        for (k = 0; k < 8; k++)
          if (want.data[8*k +: 8] != got.data[8*k +: 8]) bad = 1'b1;
        if (bad) note_mismatch("field differs", want, got);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // -------------------------------------------------------------------------
  initial begin
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        while (hold_cycles > 0) begin
          @(posedge clk);
          hold_cycles--;
        end
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic send_frame(input can_rx_t f);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    rx_id     <= f.id;
    rx_length <= f.len;
    rx_byte0  <= f.data[7:0];
    rx_byte1  <= f.data[15:8];
    rx_byte2  <= f.data[23:16];
    rx_byte3  <= f.data[31:24];
    rx_byte4  <= f.data[39:32];
    rx_byte5  <= f.data[47:40];
    rx_byte6  <= f.data[55:48];
    rx_byte7  <= f.data[63:56];
    do @(posedge clk); while (!in_ready);
    predict_reply(f);
  endtask

  // wait until the block has nothing left in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx) inside
      sdo_pkg::REG_NODE_NUMBER: node_id = data[7:0];
      sdo_pkg::REG_BOARD_MODEL, sdo_pkg::REG_BOARD_FW, sdo_pkg::REG_BOARD_CAPS,
      sdo_pkg::REG_BOARD_INPUTS, sdo_pkg::REG_BOARD_OUTS:
        board_word[idx - 3'd1] = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] node, input logic [31:0] w0,
                           input logic [31:0] w1, input logic [31:0] w2,
                           input logic [31:0] w3, input logic [31:0] w4);
    settle();
    write_reg(sdo_pkg::REG_NODE_NUMBER, 32'(node));
    write_reg(sdo_pkg::REG_BOARD_MODEL, w0);
    write_reg(sdo_pkg::REG_BOARD_FW, w1);
    write_reg(sdo_pkg::REG_BOARD_CAPS, w2);
    write_reg(sdo_pkg::REG_BOARD_INPUTS, w3);
    write_reg(sdo_pkg::REG_BOARD_OUTS, w4);
  endtask

  function automatic can_rx_t sdo_frame(input logic [7:0] cmd, input logic [15:0] idx,
                                        input logic [7:0] sub, input logic [31:0] val);
    can_rx_t f;
    f.id   = sdo_pkg::RX_BASE + 11'(node_id);
    f.len  = sdo_pkg::FRAME_DLC;
    f.data = {val, sub, idx, cmd};
    return f;
  endfunction

  // mostly addressed, well-formed requests; the rest is noise
  function automatic can_rx_t random_frame();
    can_rx_t     f;
    logic [7:0]  cmd, sub;
    logic [15:0] idx;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      cmd = sdo_pkg::CMD_UPLOAD;
    else if (pick < 55) cmd = sdo_pkg::CMD_DL_FOUR;
    else if (pick < 70) cmd = sdo_pkg::CMD_DL_TWO;
    else if (pick < 85) cmd = sdo_pkg::CMD_DL_ONE;
    else                cmd = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30)      idx = sdo_pkg::IDX_INPUTS;
    else if (pick < 60) idx = sdo_pkg::IDX_OUTPUTS;
    else if (pick < 85) idx = sdo_pkg::IDX_BOARD;
    else                idx = 16'($urandom);
    sub = ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'($urandom_range(0, 18));
    f = sdo_frame(cmd, idx, sub, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8)       f.id   = 11'($urandom);
    else if (pick < 16) f.len  = 4'($urandom);
    else if (pick < 22) f.data = {$urandom, $urandom};
    return f;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_unconfigured();
    can_rx_t f;
    // node 255: even the matching identifier is ignored
    send_frame(sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_INPUTS, 8'd0, 32'd0));
    f = sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_BOARD, 8'd1, 32'd0);
    f.id = sdo_pkg::RX_BASE;
    send_frame(f);
  endtask

  task automatic test_board_words();
    int s;
    configure(8'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_5A5A,
              32'h0000_0001, 32'h8000_0000);
    for (s = 0; s <= 6; s++)
      send_frame(sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_BOARD, 8'(s), 32'd0));
  endtask

  task automatic test_channel_tables();
    // uploads at the edges of both tables, reset contents first
    send_frame(sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_INPUTS, 8'd0, 32'd0));
    send_frame(sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_INPUTS, 8'd1, 32'd0));
    send_frame(sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_INPUTS, 8'(N_IN), 32'd0));
    send_frame(sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_INPUTS, 8'(N_IN + 1), 32'd0));
    send_frame(sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_OUTPUTS, 8'd0, 32'd0));
    send_frame(sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_OUTPUTS, 8'd1, 32'd0));
    send_frame(sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_OUTPUTS, 8'(N_OUT), 32'd0));
    send_frame(sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_OUTPUTS, 8'(N_OUT + 1), 32'd0));
    // downloads, masked to the entry width, then read back
    send_frame(sdo_frame(sdo_pkg::CMD_DL_FOUR, sdo_pkg::IDX_INPUTS, 8'd1, 32'hFFFF_FFFF));
    send_frame(sdo_frame(sdo_pkg::CMD_DL_TWO, sdo_pkg::IDX_OUTPUTS, 8'(N_OUT),
                         32'hFFFF_FFFF));
    send_frame(sdo_frame(sdo_pkg::CMD_DL_ONE, sdo_pkg::IDX_INPUTS, 8'(N_IN), 32'h0000_0000));
    send_frame(sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_INPUTS, 8'd1, 32'd0));
    send_frame(sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_OUTPUTS, 8'(N_OUT), 32'd0));
    // download aborts: subindex zero, wrong index, channel out of range
    send_frame(sdo_frame(sdo_pkg::CMD_DL_FOUR, sdo_pkg::IDX_INPUTS, 8'd0, 32'h1234_5678));
    send_frame(sdo_frame(sdo_pkg::CMD_DL_TWO, sdo_pkg::IDX_BOARD, 8'd1, 32'h1234_5678));
    send_frame(sdo_frame(sdo_pkg::CMD_DL_ONE, sdo_pkg::IDX_OUTPUTS, 8'(N_OUT + 1),
                         32'h1234_5678));
  endtask

  task automatic test_other_frames();
    can_rx_t f;
    send_frame(sdo_frame(8'h00, sdo_pkg::IDX_BOARD, 8'd1, 32'd0));
    send_frame(sdo_frame(8'hFF, sdo_pkg::IDX_INPUTS, 8'd1, 32'hFFFF_FFFF));
    send_frame(sdo_frame(8'h41, sdo_pkg::IDX_OUTPUTS, 8'd1, 32'd0));
    // ignored: wrong length code, wrong identifier
    f = sdo_frame(sdo_pkg::CMD_UPLOAD, sdo_pkg::IDX_BOARD, 8'd1, 32'd0);
    f.len = 4'd7;
    send_frame(f);
    f.len = 4'd15;
    send_frame(f);
    f.len = sdo_pkg::FRAME_DLC;
    f.id  = sdo_pkg::RX_BASE + 11'(node_id) + 11'd1;
    send_frame(f);
    f.id  = 11'h7FF;
    send_frame(f);
  endtask

  task automatic test_backpressure();
    int n;
    configure(8'd42, $urandom, $urandom, $urandom, $urandom, $urandom);
    idle_enable = 1'b0;
    hold_cycles = 300;
    for (n = 0; n < 40; n++)
      send_frame(random_frame());
    settle();
    idle_enable = 1'b1;
  endtask

  task automatic run_random_phase(input logic [7:0] node, input int items, input bit quiet);
    int n;
    configure(node, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (n = 0; n < items; n++) begin
      // alternate stretches with and without idling
      if (n % 50 == 0) idle_enable = quiet ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      send_frame(random_frame());
    end
  endtask

  task automatic test_random();
    run_random_phase(8'd254, 320, 1'b0);
    configure(8'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (40) send_frame(random_frame());
    run_random_phase(sdo_pkg::NODE_UNCONFIGURED, 60, 1'b0);
    run_random_phase(8'($urandom_range(0, 254)), 320, 1'b0);
    run_random_phase(8'($urandom_range(0, 254)), 320, 1'b0);
    run_random_phase(8'd0, 400, 1'b1);
  endtask

  initial begin
    node_id = sdo_pkg::NODE_UNCONFIGURED;
    for (int i = 0; i < sdo_pkg::BOARD_WORDS; i++) board_word[i] = '0;
    for (int i = 0; i < N_IN; i++) in_chan[i] = sdo_pkg::IN_ENTRY_RESET;
    for (int i = 0; i < N_OUT; i++) out_chan[i] = sdo_pkg::OUT_ENTRY_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unconfigured();
    test_board_words();
    test_channel_tables();
    test_other_frames();
    test_backpressure();
    test_random();

    settle();
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sdo_pkg.sv
rtl/core/sdo_expedited_server.sv
verif/tb_sdo_expedited_server.sv
